>>> sv/voxel_box_collision_query_assert.svh
// ----------------------------------------------------------------------------
// voxel_box_collision_query_assert.svh
// Assertion macros used by the voxel box collision query RTL.
// ----------------------------------------------------------------------------
`ifndef VOXEL_BOX_COLLISION_QUERY_ASSERT_SVH
`define VOXEL_BOX_COLLISION_QUERY_ASSERT_SVH

// Check a property on every clock edge outside reset
`define VBCQ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Check a property on every clock edge, reset included
`define VBCQ_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

>>> sv/vbcq_pkg.sv
// ----------------------------------------------------------------------------
// vbcq_pkg
// Field widths and codes of the voxel box collision query block.
// ----------------------------------------------------------------------------
`default_nettype none

package vbcq_pkg;

  // Field widths
  localparam int unsigned POS_W      = 24;
  localparam int unsigned EXT_W      = 23;
  localparam int unsigned FRAC_W     = 8;
  localparam int unsigned CELL_W     = 5;
  localparam int unsigned CODE_W     = 8;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 24;

  // Request types
  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ORG_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ORG_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ORG_Z = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_EMPTY = 2'd3;

endpackage

`default_nettype wire

>>> sv/vbcq_if.sv
// ----------------------------------------------------------------------------
// vbcq_if
// Request, response and configuration channels with valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface vbcq_req_if;
  import vbcq_pkg::*;

  logic                     valid;
  logic                     ready;
  logic                     req_type;
  logic [CELL_W-1:0]        cell_x;
  logic [CELL_W-1:0]        cell_y;
  logic [CELL_W-1:0]        cell_z;
  logic [CODE_W-1:0]        cell_code;
  logic signed [POS_W-1:0]  box_x;
  logic signed [POS_W-1:0]  box_y;
  logic signed [POS_W-1:0]  box_z;
  logic [EXT_W-1:0]         extent_x;
  logic [EXT_W-1:0]         extent_y;
  logic [EXT_W-1:0]         extent_z;

  modport source (
    output valid, req_type, cell_x, cell_y, cell_z, cell_code,
    output box_x, box_y, box_z, extent_x, extent_y, extent_z,
    input  ready
  );
  modport sink (
    input  valid, req_type, cell_x, cell_y, cell_z, cell_code,
    input  box_x, box_y, box_z, extent_x, extent_y, extent_z,
    output ready
  );
endinterface

interface vbcq_rsp_if;
  logic valid;
  logic ready;
  logic hit;

  modport source (output valid, hit, input ready);
  modport sink   (input valid, hit, output ready);
endinterface

interface vbcq_cfg_if;
  import vbcq_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> sv/vbcq_axis.sv
// ----------------------------------------------------------------------------
// vbcq_axis
// Shared axis unit: chunk-relative floor and clamp of one box axis.
// ----------------------------------------------------------------------------
`default_nettype none

module vbcq_axis #(
  parameter int unsigned SIDE = 32,
  parameter int unsigned IW   = 5
) (
  input  logic signed [vbcq_pkg::POS_W-1:0] pos_i,
  input  logic [vbcq_pkg::EXT_W-1:0]        ext_i,
  input  logic signed [vbcq_pkg::POS_W-1:0] org_i,
  output logic [IW-1:0]                     lo_o,
  output logic [IW-1:0]                     hi_o,
  output logic                              empty_o
);
  import vbcq_pkg::*;

  localparam int unsigned CW = POS_W - FRAC_W;
  localparam logic [CW:0] SideM1 = (CW+1)'(SIDE - 1);

  logic [POS_W:0]   rel;
  logic [POS_W+1:0] fin;
  logic [CW:0]      a_cell;
  logic [CW+1:0]    b_cell;
  logic [CW-1:0]    lo_full;
  logic [CW:0]      hi_full;

  // Box ends relative to the chunk origin
  assign rel = {pos_i[POS_W-1], pos_i} - {org_i[POS_W-1], org_i};
  assign fin = {rel[POS_W], rel} + {{(POS_W+2-EXT_W){1'b0}}, ext_i};

  // Floor to cell index: drop the fraction bits of a two's complement value
  assign a_cell = rel[POS_W:FRAC_W];
  assign b_cell = fin[POS_W+1:FRAC_W];

  // Clamp the lower end to 0 and the upper end to the last cell
  assign lo_full = a_cell[CW] ? '0 : a_cell[CW-1:0];

  always_comb begin
    if (b_cell[CW+1]) begin
      hi_full = '0;
    end else if (b_cell[CW:0] > SideM1) begin
      hi_full = SideM1;
    end else begin
      hi_full = b_cell[CW:0];
    end
  end

  // Upper end below the chunk, or lower end past the upper one
  assign empty_o = b_cell[CW+1] || ({1'b0, lo_full} > hi_full);

  assign lo_o = lo_full[IW-1:0];
  assign hi_o = hi_full[IW-1:0];

endmodule

`default_nettype wire

>>> sv/vbcq_store.sv
// ----------------------------------------------------------------------------
// vbcq_store
// Voxel code memory: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module vbcq_store #(
  parameter int unsigned AW = 15
) (
  input  logic                          clk_i,
  input  logic                          we_i,
  input  logic [AW-1:0]                 waddr_i,
  input  logic [vbcq_pkg::CODE_W-1:0]   wdata_i,
  input  logic                          re_i,
  input  logic [AW-1:0]                 raddr_i,
  output logic [vbcq_pkg::CODE_W-1:0]   rdata_o
);
  import vbcq_pkg::*;

  logic [CODE_W-1:0] mem_q [2**AW];
  logic [CODE_W-1:0] rdata_q;

  // Store one cell code
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read one cell code a cycle while the read enable is high
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> sv/voxel_box_collision_query.sv
// Cell write: after accept, the result word is loaded from the done state.
// Box query: the shared axis unit takes x, y and z in turn, then one memory read
// per covered cell; a miss gives its result through the drain and done states,
// a hit stops the scan early. An empty range goes from the axis steps to done.
// One request at a time; the next is taken as soon as the result is registered.
// Reset clears control and configuration; the voxel store is not cleared.
// ----------------------------------------------------------------------------
// voxel_box_collision_query
// Voxel chunk store with box occupancy query, scanned one cell per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
`include "voxel_box_collision_query_assert.svh"

module voxel_box_collision_query #(
  parameter int unsigned SIDE = 32
) (
  input  logic clk_i,
  input  logic rst_ni,
  vbcq_req_if.sink   req_i,
  vbcq_rsp_if.source rsp_o,
  vbcq_cfg_if.sink   cfg_i
);
  import vbcq_pkg::*;

  localparam int unsigned IW = (SIDE > 1) ? $clog2(SIDE) : 1;
  localparam int unsigned AW = 3 * IW;
  localparam logic [8:0]  SideW = 9'(SIDE);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_AXIS  = 5'b00010,
    S_SCAN  = 5'b00100,
    S_DRAIN = 5'b01000,
    S_DONE  = 5'b10000
  } state_e;

  state_e state_q, state_d;

  logic [1:0]              axis_q, axis_d;
  logic                    empty_q, empty_d;
  logic                    rvalid_q, rvalid_d;
  logic                    hit_q, hit_d;
  logic                    out_valid_q, out_valid_d;
  logic                    out_hit_q, out_hit_d;
  logic [IW-1:0]           x_q, x_d, y_q, y_d, z_q, z_d;

  logic signed [POS_W-1:0] box_q [3];
  logic [EXT_W-1:0]        ext_q [3];
  logic [IW-1:0]           lo_q  [3];
  logic [IW-1:0]           hi_q  [3];
  logic signed [POS_W-1:0] org_q [3];
  logic [CODE_W-1:0]       empty_code_q;

  logic                    req_acc;
  logic                    wr_in_range;
  logic                    mem_we;
  logic [AW-1:0]           mem_waddr;
  logic                    mem_re;
  logic [CODE_W-1:0]       mem_rdata;
  logic [IW-1:0]           ax_lo, ax_hi;
  logic                    ax_empty;
  logic                    hit_now;
  logic                    x_last, y_last, z_last, scan_last;

  // Handshakes
  assign req_i.ready = (state_q == S_IDLE);
  assign req_acc     = req_i.valid && req_i.ready;
  assign cfg_i.ready = 1'b1;
  assign rsp_o.valid = out_valid_q;
  assign rsp_o.hit   = out_hit_q;

  // Cell writes go straight to the store; drop those outside the chunk
  assign wr_in_range = ({4'b0, req_i.cell_x} < SideW) && ({4'b0, req_i.cell_y} < SideW)
                    && ({4'b0, req_i.cell_z} < SideW);
  assign mem_we      = req_acc && (req_i.req_type == REQ_WRITE) && wr_in_range;
  assign mem_waddr   = {IW'(req_i.cell_x), IW'(req_i.cell_y), IW'(req_i.cell_z)};
  assign mem_re      = (state_q == S_SCAN);

  vbcq_store #(
    .AW (AW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (req_i.cell_code),
    .re_i    (mem_re),
    .raddr_i ({x_q, y_q, z_q}),
    .rdata_o (mem_rdata)
  );

  // One axis unit, stepped over x, y and z
  vbcq_axis #(
    .SIDE (SIDE),
    .IW   (IW)
  ) u_axis (
    .pos_i   (box_q[axis_q]),
    .ext_i   (ext_q[axis_q]),
    .org_i   (org_q[axis_q]),
    .lo_o    (ax_lo),
    .hi_o    (ax_hi),
    .empty_o (ax_empty)
  );

  // Scan position and hit detection
  assign x_last    = (x_q == hi_q[0]);
  assign y_last    = (y_q == hi_q[1]);
  assign z_last    = (z_q == hi_q[2]);
  assign scan_last = x_last && y_last && z_last;
  assign hit_now   = rvalid_q && (mem_rdata != empty_code_q);

  // Sequencer
  always_comb begin
    state_d     = state_q;
    axis_d      = axis_q;
    empty_d     = empty_q;
    rvalid_d    = rvalid_q;
    hit_d       = hit_q;
    x_d         = x_q;
    y_d         = y_q;
    z_d         = z_q;
    out_valid_d = out_valid_q;
    out_hit_d   = out_hit_q;

    if (rsp_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (req_acc) begin
          if (req_i.req_type == REQ_QUERY) begin
            axis_d  = 2'd0;
            empty_d = 1'b0;
            state_d = S_AXIS;
          end else begin
            hit_d   = 1'b0;
            state_d = S_DONE;
          end
        end
      end
      S_AXIS: begin
        empty_d = empty_q || ax_empty;
        axis_d  = axis_q + 2'd1;
        if (axis_q == 2'd2) begin
          axis_d = 2'd0;
          if (empty_q || ax_empty) begin
            hit_d   = 1'b0;
            state_d = S_DONE;
          end else begin
            x_d      = lo_q[0];
            y_d      = lo_q[1];
            z_d      = ax_lo;
            rvalid_d = 1'b0;
            state_d  = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (hit_now) begin
          hit_d    = 1'b1;
          rvalid_d = 1'b0;
          state_d  = S_DONE;
        end else begin
          rvalid_d = 1'b1;
          if (z_last) begin
            z_d = lo_q[2];
            if (y_last) begin
              y_d = lo_q[1];
              x_d = x_q + IW'(1);
            end else begin
              y_d = y_q + IW'(1);
            end
          end else begin
            z_d = z_q + IW'(1);
          end
          if (scan_last) begin
            state_d = S_DRAIN;
          end
        end
      end
      S_DRAIN: begin
        hit_d    = hit_now;
        rvalid_d = 1'b0;
        state_d  = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || rsp_o.ready) begin
          out_valid_d = 1'b1;
          out_hit_d   = hit_q;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control and configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      axis_q       <= 2'd0;
      empty_q      <= 1'b0;
      rvalid_q     <= 1'b0;
      out_valid_q  <= 1'b0;
      org_q[0]     <= '0;
      org_q[1]     <= '0;
      org_q[2]     <= '0;
      empty_code_q <= '0;
    end else begin
      state_q     <= state_d;
      axis_q      <= axis_d;
      empty_q     <= empty_d;
      rvalid_q    <= rvalid_d;
      out_valid_q <= out_valid_d;
      if (cfg_i.valid && cfg_i.ready) begin
        case (cfg_i.index)
          CFG_ORG_X: org_q[0]     <= POS_W'(cfg_i.data);
          CFG_ORG_Y: org_q[1]     <= POS_W'(cfg_i.data);
          CFG_ORG_Z: org_q[2]     <= POS_W'(cfg_i.data);
          CFG_EMPTY: empty_code_q <= cfg_i.data[CODE_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    hit_q     <= hit_d;
    out_hit_q <= out_hit_d;
    x_q       <= x_d;
    y_q       <= y_d;
    z_q       <= z_d;
    if (req_acc) begin
      box_q[0] <= req_i.box_x;
      box_q[1] <= req_i.box_y;
      box_q[2] <= req_i.box_z;
      ext_q[0] <= req_i.extent_x;
      ext_q[1] <= req_i.extent_y;
      ext_q[2] <= req_i.extent_z;
    end
    if (state_q == S_AXIS) begin
      lo_q[axis_q] <= ax_lo;
      hi_q[axis_q] <= ax_hi;
    end
  end

  // Assertions
  `VBCQ_ASSERT(a_idle_no_read, (state_q != S_IDLE) || !rvalid_q,
    "read data flagged valid while idle")
  `VBCQ_ASSERT(a_drain_after_scan, (state_q == S_DRAIN) |-> ($past(state_q) == S_SCAN),
    "drain entered from outside the scan")
  `VBCQ_ASSERT(a_drain_has_data, (state_q == S_DRAIN) |-> rvalid_q,
    "drain without read data of the last cell")
  `VBCQ_ASSERT(a_scan_in_range,
    (state_q == S_SCAN) |-> ((x_q <= hi_q[0]) && (y_q <= hi_q[1]) && (z_q <= hi_q[2])),
    "scan position beyond the clamped range")
  `VBCQ_ASSERT(a_result_from_done, $rose(out_valid_q) |-> ($past(state_q) == S_DONE),
    "result word loaded outside the done state")

endmodule

`default_nettype wire
